### hdl/dsec_pkg.sv
// Shared types, constants and the low-S bound table for the DER signature checker.
package dsec_pkg;

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] HASH_MASK    = 8'h1F;
    localparam int unsigned MIN_DER_LENGTH = 8;
    localparam int unsigned MAX_S_LENGTH   = 32;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QUEUE_AW       = $clog2(QUEUE_DEPTH);

    localparam logic [255:0] S_BOUND =
        256'h7FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF5D576E7357A4501DDFE92F46681B20A0;

    localparam int unsigned REG_AW = 4;

    typedef enum logic [1:0] {
        REG_DER_STRICT  = 2'd0,
        REG_LOW_S       = 2'd1,
        REG_STRICT_HASH = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FINAL = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CMP_EQUAL   = 2'd0,
        CMP_LESS    = 2'd1,
        CMP_GREATER = 2'd2
    } t_cmp;

    typedef enum logic [1:0] {
        FAIL_NONE = 2'd0,
        FAIL_DER  = 2'd1,
        FAIL_HIGH = 2'd2,
        FAIL_HASH = 2'd3
    } t_fail;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_word;

    typedef struct packed {
        logic der_strict;
        logic low_s_required;
        logic strict_hash_type;
    } t_cfg;

    function automatic logic [7:0] s_bound_byte(input logic [4:0] idx);
        logic [4:0] rev;
        rev = 5'd31 - idx;
        return S_BOUND[{rev, 3'b000} +: 8];
    endfunction

endpackage

### hdl/dsec_front.sv
// Input stage that registers each word and classifies it as data, final or empty.
module dsec_front
    import dsec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       s_axis_tuser,
    output logic       o_push,
    output t_word      o_word,
    input  logic       i_queue_full
);

    logic  r_valid;
    t_word r_word;
    t_word n_word;

    assign o_push        = r_valid && !i_queue_full;
    assign s_axis_tready = !r_valid || !i_queue_full;
    assign o_word        = r_word;

    always_comb begin
        n_word.data = s_axis_tdata;
        priority if (s_axis_tuser) begin
            n_word.kind = KIND_EMPTY;
        end else if (s_axis_tlast) begin
            n_word.kind = KIND_FINAL;
        end else begin
            n_word.kind = KIND_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_word <= n_word;
        end
    end

endmodule

### hdl/dsec_queue.sv
// Short word queue between the input stage and the checker.
module dsec_queue
    import dsec_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_word i_word,
    output logic  o_full,
    output logic  o_valid,
    output t_word o_word,
    input  logic  i_pop
);

    t_word                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 1 && i_pop && !i_push) |=> !o_valid)
        else $error("queue not empty after last word left");
`endif

endmodule

### hdl/dsec_back.sv
// Signature checker: walks the DER structure, compares S and issues the verdict.
module dsec_back
    import dsec_pkg::*;
#(
    parameter int unsigned MAX_DER_LENGTH = 72
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  t_word      i_word,
    output logic       o_pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata
);

    localparam int unsigned CW = $clog2(MAX_DER_LENGTH + 1);

    logic [CW-1:0] r_count;
    logic [7:0]    r_declared;
    logic [7:0]    r_rlen;
    logic [7:0]    r_slen;
    logic [7:0]    r_first;
    logic          r_der_err;
    t_cmp          r_cmp;
    logic          r_out_valid;
    logic          r_accepted;
    t_fail         r_fail;

    logic [CW-1:0] n_count;
    logic [7:0]    n_declared;
    logic [7:0]    n_rlen;
    logic [7:0]    n_slen;
    logic [7:0]    n_first;
    logic          n_der_err;
    t_cmp          n_cmp;
    logic          n_accepted;
    t_fail         n_fail;

    logic [9:0] pos;
    logic [9:0] rlen_x;
    logic [9:0] slen_x;
    logic [9:0] j;
    logic [7:0] b;
    logic [7:0] h;
    logic [7:0] hash_base;
    logic       out_free;
    logic       makes_result;
    logic       der_ok;
    logic       take;

    assign b        = i_word.data;
    assign pos      = 10'(r_count);
    assign rlen_x   = {2'b00, r_rlen};
    assign slen_x   = {2'b00, r_slen};
    assign j        = pos - rlen_x - 10'd6;
    assign h        = s_bound_byte(5'(j - slen_x));
    assign out_free = !r_out_valid || m_axis_tready;
    assign makes_result = (i_word.kind != KIND_DATA);
    assign o_pop    = i_valid && (!makes_result || out_free);
    assign take     = o_pop && (i_word.kind == KIND_DATA);
    assign hash_base = b & HASH_MASK;

    assign der_ok = !r_der_err
        && (pos >= 10'(MIN_DER_LENGTH))
        && (pos <= 10'(MAX_DER_LENGTH))
        && ({2'b00, r_declared} + 10'd2 == pos)
        && ({2'b00, r_declared} == rlen_x + slen_x + 10'd4)
        && (rlen_x + slen_x + 10'd6 == pos);

    always_comb begin
        n_count    = r_count;
        n_declared = r_declared;
        n_rlen     = r_rlen;
        n_slen     = r_slen;
        n_first    = r_first;
        n_der_err  = r_der_err;
        n_cmp      = r_cmp;
        if (r_count >= CW'(MAX_DER_LENGTH)) begin
            n_der_err = 1'b1;
        end else begin
            n_count = r_count + 1'b1;
            priority if (pos == 10'd0) begin
                if (b != TAG_SEQUENCE) n_der_err = 1'b1;
            end else if (pos == 10'd1) begin
                n_declared = b;
            end else if (pos == 10'd2) begin
                if (b != TAG_INTEGER) n_der_err = 1'b1;
            end else if (pos == 10'd3) begin
                n_rlen = b;
                if (b == 8'd0) n_der_err = 1'b1;
            end else if (pos == rlen_x + 10'd4) begin
                if (b != TAG_INTEGER) n_der_err = 1'b1;
            end else if (pos == rlen_x + 10'd5) begin
                n_slen = b;
                if (b == 8'd0) n_der_err = 1'b1;
            end else if (pos < rlen_x + 10'd4) begin
                if (pos == 10'd4) begin
                    if (b[7]) n_der_err = 1'b1;
                    n_first = b;
                end else if (pos == 10'd5 && r_rlen > 8'd1) begin
                    if (r_first == 8'd0 && !b[7]) n_der_err = 1'b1;
                end
            end else begin
                if (j == 10'd0) begin
                    if (b[7]) n_der_err = 1'b1;
                    n_first = b;
                end else if (j == 10'd1 && r_slen > 8'd1) begin
                    if (r_first == 8'd0 && !b[7]) n_der_err = 1'b1;
                end
                if (j < slen_x && slen_x <= 10'(MAX_S_LENGTH) && r_cmp == CMP_EQUAL) begin
                    if (b < h) begin
                        n_cmp = CMP_LESS;
                    end else if (b > h) begin
                        n_cmp = CMP_GREATER;
                    end
                end
            end
        end
    end

    always_comb begin
        n_accepted = 1'b1;
        n_fail     = FAIL_NONE;
        priority if (i_word.kind == KIND_EMPTY) begin
            n_accepted = 1'b1;
            n_fail     = FAIL_NONE;
        end else if ((i_cfg.der_strict || i_cfg.low_s_required) && !der_ok) begin
            n_accepted = 1'b0;
            n_fail     = FAIL_DER;
        end else if (i_cfg.low_s_required
                     && (slen_x > 10'(MAX_S_LENGTH) || r_cmp == CMP_GREATER)) begin
            n_accepted = 1'b0;
            n_fail     = FAIL_HIGH;
        end else if (i_cfg.strict_hash_type
                     && (hash_base < 8'd1 || hash_base > 8'd3)) begin
            n_accepted = 1'b0;
            n_fail     = FAIL_HASH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_declared <= '0;
            r_rlen     <= '0;
            r_slen     <= '0;
            r_first    <= '0;
            r_der_err  <= 1'b0;
            r_cmp      <= CMP_EQUAL;
        end else if (o_pop) begin
            if (take) begin
                r_count    <= n_count;
                r_declared <= n_declared;
                r_rlen     <= n_rlen;
                r_slen     <= n_slen;
                r_first    <= n_first;
                r_der_err  <= n_der_err;
                r_cmp      <= n_cmp;
            end else begin
                r_count    <= '0;
                r_declared <= '0;
                r_rlen     <= '0;
                r_slen     <= '0;
                r_first    <= '0;
                r_der_err  <= 1'b0;
                r_cmp      <= CMP_EQUAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_pop && makes_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && makes_result) begin
            r_accepted <= n_accepted;
            r_fail     <= n_fail;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_fail, r_accepted};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_DER_LENGTH))
        else $error("byte count beyond maximum length");
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_accepted == (r_fail == FAIL_NONE)))
        else $error("verdict and failure code disagree");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && makes_result) |=> (r_count == '0 && r_cmp == CMP_EQUAL && !r_der_err))
        else $error("signature state not cleared after verdict");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(o_pop && makes_result))
        else $error("verdict issued while output held");
`endif

endmodule

### hdl/der_signature_encoding_checker.sv
// Top level of the DER signature checker with its register port.
// Usage:
//   The input stream carries one signature as a run of words: each word holds one
//   DER byte, the last word of the run (tlast high) holds the hash-type byte. A
//   word with tuser high stands for an empty signature and ends the run.
//   For each run one result word leaves on the output stream: bit 0 accepted,
//   bits 2:1 failure code (0 ok, 1 bad DER, 2 S too high, 3 bad hash type).
//   The three mode registers sit at byte addresses 0, 4 and 8 of the register
//   port; the user must write them only while no signature is in flight (not enforced).
// Timing:
//   One word is taken every cycle unless the input register and queue are full. A
//   final word passes through the input register and the four-word queue; the
//   checker loads its output register at the edge that pops the word.
//   When the output is stalled, the checker keeps consuming DER bytes and stops
//   only at the next final word; the queue then fills and the input deasserts
//   tready after it and the input register are full.
// Reset:
//   Synchronous, active low. It clears the mode registers, the queue, the
//   signature state and the output valid; no clearing pass is needed.
module der_signature_encoding_checker
    import dsec_pkg::*;
#(
    parameter int unsigned MAX_DER_LENGTH = 72
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,  // [7:0] sig_byte
    input  logic              s_axis_tlast,
    input  logic              s_axis_tuser,  // [0] empty_marker
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,  // [0] accepted, [2:1] fail_reason, [7:3] zero
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [REG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg       r_cfg;
    t_reg_index reg_index;
    logic       wr_en;
    logic       push;
    logic       queue_full;
    logic       queue_valid;
    logic       pop;
    t_word      front_word;
    t_word      queue_word;

    assign pready    = 1'b1;
    assign reg_index = t_reg_index'(paddr[REG_AW-1:2]);
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_DER_STRICT:  r_cfg.der_strict       <= pwdata[0];
                REG_LOW_S:       r_cfg.low_s_required   <= pwdata[0];
                REG_STRICT_HASH: r_cfg.strict_hash_type <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_DER_STRICT:  prdata[0] = r_cfg.der_strict;
            REG_LOW_S:       prdata[0] = r_cfg.low_s_required;
            REG_STRICT_HASH: prdata[0] = r_cfg.strict_hash_type;
            default:         prdata    = '0;
        endcase
    end

    dsec_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (push),
        .o_word        (front_word),
        .i_queue_full  (queue_full)
    );

    dsec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_word  (queue_word),
        .i_pop   (pop)
    );

    dsec_back #(
        .MAX_DER_LENGTH (MAX_DER_LENGTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (queue_valid),
        .i_word        (queue_word),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
